[rtl/core/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Field widths, op codes and the structs that run along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int CAP_RST     = 16;

  localparam logic             OP_GET     = 1'b0;
  localparam logic             OP_PUT     = 1'b1;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic             upd;       // apply the update this cycle
    logic             put;       // current item is a put
    logic             any_hit;   // some cell matched the key
    logic [CAP_W-1:0] capacity;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  // Contents handed from one cell to the next older one
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cell_data_t;

endpackage

`default_nettype wire

[rtl/core/lkvc_cell.sv]
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the recency chain
// Holds a key/value pair. Cell 0 is the most recent entry; on update a cell
// takes the contents of its younger neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_cell #(
  parameter int IDX = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire lkvc_pkg::cell_ctl_t     ctl,
  input  wire lkvc_pkg::cell_data_t    prev_data,
  input  wire                          hit_ge_in,   // match in an older cell
  input  wire [lkvc_pkg::VAL_W-1:0]    rd_in,
  output lkvc_pkg::cell_data_t         data,
  output logic                         hit,
  output logic                         hit_ge_out,
  output logic [lkvc_pkg::VAL_W-1:0]   rd_out
);

  logic                        valid_r, valid_nxt;
  logic [lkvc_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lkvc_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic                        in_cap;
  logic                        shift;

  assign hit        = valid_r && (key_r == ctl.key);
  assign hit_ge_out = hit | hit_ge_in;
  assign rd_out     = rd_in | (hit ? value_r : '0);
  assign in_cap     = (IDX < int'(ctl.capacity));

  // hit: cells up to the matching one move down; miss put: whole used range moves
  assign shift = ctl.upd && (ctl.any_hit ? hit_ge_out : (ctl.put && in_cap));

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (shift) begin
      valid_nxt = prev_data.valid;
      key_nxt   = prev_data.key;
      value_nxt = prev_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign data = '{valid: valid_r, key: key_r, value: value_r};

endmodule

`default_nettype wire

[rtl/core/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Entries sit in a chain of cells ordered from most to least recent.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_*) carry one get or put; in_tuser is the op.
//   Each beat yields exactly one result beat (out_*): out_tuser is the hit
//   flag, out_tdata the stored value on a get hit and all ones otherwise.
//   Timing: a beat is taken while idle; in the busy state, once the output
//   register is free, all cells compare its key and shift and the result
//   is registered; no beat is taken while busy. The rate is set by the
//   single compare-and-shift pass over the chain that each item depends on.
//   A finished result sits in an output register; the next beat may be taken
//   while it waits. If the receiver stalls, the following item holds in the
//   update cycle until the output register frees up.
//   cfg_data sets capacity (0 reads as 1, clamped to ENTRIES); it is taken
//   only while the store is empty and ignored otherwise. cfg_ready is high.
//   Reset (rst_n low, synchronous) empties the store and sets capacity to
//   16 (or ENTRIES if smaller).
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,    // [31:0] key, [63:32] value
  input  wire         in_tuser,    // [0] op
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,   // [31:0] read_value
  output logic        out_tuser,   // [0] hit
  // configuration
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [4:0]  cfg_data     // [4:0] capacity
);

  localparam int KW = lkvc_pkg::KEY_W;
  localparam int VW = lkvc_pkg::VAL_W;
  localparam int CW = lkvc_pkg::CAP_W;
  localparam int CAP_INIT = (ENTRIES < lkvc_pkg::CAP_RST) ? ENTRIES : lkvc_pkg::CAP_RST;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic              op_r;
  logic [KW-1:0]     key_r;
  logic [VW-1:0]     value_r;
  logic [CW-1:0]     capacity_r, capacity_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic [VW-1:0]     out_data_r;
  logic              upd;
  logic [CW-1:0]     cap_wr;

  lkvc_pkg::cell_ctl_t  ctl;
  lkvc_pkg::cell_data_t cell_data [ENTRIES];
  lkvc_pkg::cell_data_t prev_data [ENTRIES];
  lkvc_pkg::cell_data_t new_entry;
  logic                 hit_ge [ENTRIES+1];
  logic [VW-1:0]        rd     [ENTRIES+1];
  logic [ENTRIES-1:0]   hit_vec;
  logic [ENTRIES-1:0]   valid_vec;

  // ---------------- control ----------------
  assign in_tready = (state_r == ST_IDLE);
  assign upd       = (state_r == ST_BUSY) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_BUSY;
      ST_BUSY: if (upd) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (upd) out_valid_nxt = 1'b1;
  end

  // capacity write, honored only while the store is empty
  always_comb begin
    cap_wr = (cfg_data == '0) ? CW'(1) : cfg_data;
    if (int'(cap_wr) > ENTRIES) cap_wr = CW'(ENTRIES);
    capacity_nxt = capacity_r;
    if (cfg_valid && !cell_data[0].valid) capacity_nxt = cap_wr;
  end
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      capacity_r  <= CW'(CAP_INIT);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      capacity_r  <= capacity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= in_tuser;
      key_r   <= in_tdata[KW-1:0];
      value_r <= in_tdata[KW+VW-1:KW];
    end
    if (upd) begin
      out_hit_r  <= hit_ge[0];
      out_data_r <= (op_r == lkvc_pkg::OP_PUT || !hit_ge[0]) ? lkvc_pkg::MISS_VALUE : rd[0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_data_r;

  // ---------------- cell chain ----------------
  assign ctl = '{
    upd:      upd,
    put:      (op_r == lkvc_pkg::OP_PUT),
    any_hit:  hit_ge[0],
    capacity: capacity_r,
    key:      key_r
  };

  // a get hit keeps the stored value as it moves to the front
  assign new_entry = '{
    valid: 1'b1,
    key:   key_r,
    value: (op_r == lkvc_pkg::OP_PUT) ? value_r : rd[0]
  };

  assign hit_ge[ENTRIES] = 1'b0;
  assign rd[ENTRIES]     = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_data[i] = new_entry;
    end else begin : g_body
      assign prev_data[i] = cell_data[i-1];
    end

    lkvc_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_data  (prev_data[i]),
      .hit_ge_in  (hit_ge[i+1]),
      .rd_in      (rd[i+1]),
      .data       (cell_data[i]),
      .hit        (hit_vec[i]),
      .hit_ge_out (hit_ge[i]),
      .rd_out     (rd[i])
    );

    assign valid_vec[i] = cell_data[i].valid;
  end

  // ---------------- assertions ----------------
  // a key is never held twice
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) |-> $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  // valid entries form an unbroken run from the front of the chain
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("hole in the valid run");

  // occupancy stays within capacity
  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) <= int'(capacity_r))
    else $error("occupancy above capacity");

  // a new result only follows an update cycle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(upd))
    else $error("result without an update");

  // capacity only moves while the store is empty
  a_cap_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (capacity_r != $past(capacity_r)) && $past(rst_n) |-> !$past(valid_vec[0]))
    else $error("capacity changed while entries held");

endmodule

`default_nettype wire

[tb/sv/lru_key_value_cache_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker: result predictor and comparator
// Watches the input, result and capacity channels of the LRU key-value
// cache. Keeps its own copy of the store, works out the reply for every
// accepted input beat and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------

module lru_key_value_cache_checker #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] key, [63:32] value
  input  logic        in_tuser,    // [0] op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,   // [31:0] read_value
  input  logic        out_tuser,   // [0] hit
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,    // [4:0] capacity
  output int          fail_count,
  output int          replies_due,
  output int          reply_count,
  output int          hit_count,
  output int          evict_count,
  output int          capacity_now
);

  typedef struct packed {
    logic                      hit;
    logic [lkvc_pkg::VAL_W-1:0] value;
  } reply_t;

  logic [lkvc_pkg::KEY_W-1:0] slot_key [ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] slot_val [ENTRIES];
  int unsigned      rank_slot [ENTRIES];  // rank 0 is least recent
  int unsigned      fill;
  int unsigned      cap;
  reply_t           due_replies [$];
  int               errs, n_replies, n_hits, n_evicts;

  function automatic void make_recent(int unsigned r);
    int unsigned s;
    s = rank_slot[r];
    for (int unsigned i = r; i + 1 < fill; i++)
      rank_slot[i] = rank_slot[i + 1];
    rank_slot[fill - 1] = s;
  endfunction

  function automatic reply_t apply_access(logic op, logic [lkvc_pkg::KEY_W-1:0] key,
                                          logic [lkvc_pkg::VAL_W-1:0] val);
    reply_t      r;
    int          found;
    int unsigned s;
    found   = -1;
    r.value = lkvc_pkg::MISS_VALUE;
    for (int i = 0; i < int'(fill); i++)
      if (found < 0 && slot_key[rank_slot[i]] == key) found = i;
    if (found >= 0) begin
      s = rank_slot[found];
      make_recent(found);
      r.hit = 1'b1;
      if (op == lkvc_pkg::OP_PUT) slot_val[s] = val;
      else r.value = slot_val[s];
    end else begin
      r.hit = 1'b0;
      if (op == lkvc_pkg::OP_PUT) begin
        if (fill >= cap && fill > 0) begin
          // full: reuse the least recent slot
          s = rank_slot[0];
          make_recent(0);
          n_evicts++;
        end else begin
          s = fill;
          rank_slot[fill] = fill;
          fill++;
        end
        slot_key[s] = key;
        slot_val[s] = val;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t      exp_r;
    reply_t      pred_r;
    int unsigned v;
    if (!rst_n) begin
      fill = 0;
      cap  = (lkvc_pkg::CAP_RST > ENTRIES) ? ENTRIES : lkvc_pkg::CAP_RST;
      due_replies.delete();
      errs = 0; n_replies = 0; n_hits = 0; n_evicts = 0;
    end else begin
      if (cfg_valid && cfg_ready && fill == 0) begin
        v = cfg_data;
        if (v == 0) v = 1;
        if (v > ENTRIES) v = ENTRIES;
        cap = v;
      end
      if (in_tvalid && in_tready) begin
        pred_r      = apply_access(in_tuser, in_tdata[31:0], in_tdata[63:32]);
        due_replies = {due_replies, pred_r};
      end
      if (out_tvalid && out_tready) begin
        if (due_replies.size() == 0) begin
          errs++;
          $display("%0t: unexpected result beat hit=%0b value=%h", $time,
                   out_tuser, out_tdata);
        end else begin
          exp_r = due_replies.pop_front();
          n_replies++;
          if (exp_r.hit) n_hits++;
          if (out_tuser !== exp_r.hit) begin
            errs++;
            $display("%0t: hit mismatch: expected %0b, got %0b", $time,
                     exp_r.hit, out_tuser);
          end
          if (out_tdata !== exp_r.value) begin
            errs++;
            $display("%0t: read_value mismatch: expected %h, got %h", $time,
                     exp_r.value, out_tdata);
          end
        end
      end
    end
    fail_count   <= errs;
    replies_due  <= due_replies.size();
    reply_count  <= n_replies;
    hit_count    <= n_hits;
    evict_count  <= n_evicts;
    capacity_now <= cap;
  end

endmodule

[tb/sv/lru_key_value_cache_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test: top-level testbench for the LRU key-value cache
// Directed gets and puts around empty, update and eviction cases, then
// random traffic over a small key pool in phases with sender gaps, receiver
// stalls and one long output hold-off. Checking is done by the checker.
// ----------------------------------------------------------------------------

module lru_key_value_cache_test;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;     // [31:0] key, [63:32] value
  logic        in_tuser;     // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [31:0] read_value
  logic        out_tuser;    // [0] hit
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;     // [4:0] capacity

  int fail_count, replies_due, reply_count, hit_count, evict_count, capacity_now;

  int          idle_in;      // percent of cycles the sender idles
  int          stall_out;    // percent of cycles the receiver stalls
  bit          hold_req;
  int          hold_left;
  int          pool_span;
  int unsigned cap_pick;
  logic [31:0] key_pool [24];

  lru_key_value_cache u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  lru_key_value_cache_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .replies_due  (replies_due),
    .reply_count  (reply_count),
    .hit_count    (hit_count),
    .evict_count  (evict_count),
    .capacity_now (capacity_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("lru_key_value_cache_test: FAIL");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_out);
      end
    end
  end

  // Called right after a rising edge; returns on the edge that takes the beat.
  task automatic send_beat(logic op, logic [31:0] key, logic [31:0] val);
    while ($urandom_range(0, 99) < idle_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, key};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random();
    logic [31:0] key, val;
    logic        op;
    op  = $urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
    key = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, pool_span - 1)]
                                       : $urandom;
    case ($urandom_range(0, 9))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      default: val = $urandom;
    endcase
    send_beat(op, key, val);
  endtask

  // Drop valid and wait until every reply is back and the pipe is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= lkvc_pkg::OP_GET;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    idle_in   = 0;
    stall_out = 0;
    hold_req  = 1'b0;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    case ($urandom_range(0, 3))
      0:       cap_pick = 1;
      1:       cap_pick = 16;
      default: cap_pick = $urandom_range(2, 15);
    endcase
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store: capacity writes land, clamped at both ends
    write_capacity(5'd0);
    send_beat(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678);
    drain();
    write_capacity(5'd31);
    write_capacity(5'd17);
    send_beat(lkvc_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    drain();
    write_capacity(cap_pick[4:0]);

    send_beat(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);   // update in place
    send_beat(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_beat(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_beat(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_beat(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    // overflow the store so the oldest keys get evicted
    for (int i = 0; i <= int'(cap_pick); i++)
      send_beat(lkvc_pkg::OP_PUT, 32'h0000_0100 + i, $urandom);
    send_beat(lkvc_pkg::OP_GET, 32'h0000_0100, 32'h0);
    send_beat(lkvc_pkg::OP_GET, 32'h0000_0100 + cap_pick, 32'h0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_in = 0;  stall_out = 0;  pool_span = cap_pick + 2;     end
        1: begin idle_in = 80; stall_out = 0;  pool_span = cap_pick / 2 + 1; end
        2: begin idle_in = 0;  stall_out = 80; pool_span = 24;               end
        default: begin idle_in = 16; stall_out = 16; pool_span = cap_pick + 1; end
      endcase
      repeat (120) send_random();
      drain();
      // store is not empty: these writes must be dropped
      case (ph)
        0: write_capacity(5'd1);
        1: write_capacity(5'd0);
        2: write_capacity(5'd31);
        default: write_capacity(5'($urandom_range(0, 31)));
      endcase
    end

    // Long output hold-off while the sender keeps pushing
    idle_in   = 0;
    stall_out = 0;
    pool_span = cap_pick + 2;
    hold_req  = 1'b1;
    repeat (40) send_random();
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("ran %0d results (%0d hits, %0d evictions) at capacity %0d", reply_count,
             hit_count, evict_count, capacity_now);
    $display("phases: directed, free-running, sender gaps, receiver stalls, mixed, hold-off");
    if (fail_count == 0) begin
      $display("lru_key_value_cache_test: PASS");
    end else begin
      $display("lru_key_value_cache_test: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_checker.sv
tb/sv/lru_key_value_cache_test.sv
